// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the byte range parser modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that prop holds in the same cycle as cond.
`define HBRP_ASSERT_IMP(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);

// Check that prop holds in the cycle after cond.
`define HBRP_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ===== rtl/hbrp_pkg.sv =====
// Shared types, constants and character helpers of the byte range parser.
package hbrp_pkg;

  localparam int unsigned ACC_W           = 64;
  localparam int unsigned OUT_W           = 63;
  localparam int unsigned OFFSET_BITS_DEF = 63;
  localparam int unsigned CFG_AW          = 4;
  localparam int unsigned CFG_DW          = 64;

  localparam logic [ACC_W-1:0] TWO63            = 64'h8000_0000_0000_0000;
  localparam logic [ACC_W-1:0] DIGIT_LIMIT      = TWO63 / 10;
  localparam logic [ACC_W-1:0] DIGIT_LIMIT_NINE = (TWO63 - 64'd9) / 10;

  localparam logic CFG_IDX_FILE_SIZE = 1'b0;

  localparam logic [7:0] CH_EQ    = 8'h3d;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5a;
  localparam logic [7:0] CASE_GAP = 8'h20;

  typedef enum logic [1:0] {
    VERDICT_OK        = 2'd0,
    VERDICT_MALFORMED = 2'd1,
    VERDICT_UNSAT     = 2'd2,
    VERDICT_MULTI     = 2'd3
  } verdict_t;

  typedef enum logic [1:0] {
    REC_NONE  = 2'd0,
    REC_OPEN  = 2'd1,
    REC_VALUE = 2'd2
  } rec_kind_t;

  typedef struct packed {
    logic                last;
    logic                header_ok;
    rec_kind_t           kind;
    logic                suffix;
    logic                neg;
    logic [ACC_W-1:0]    mag;
    logic [OUT_W-1:0]    part_start;
  } rec_t;

  function automatic logic is_blank(input logic [7:0] c);
    is_blank = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic [7:0] unit_char(input logic [2:0] idx);
    unique case (idx)
      3'd0:    unit_char = 8'h62;
      3'd1:    unit_char = 8'h79;
      3'd2:    unit_char = 8'h74;
      3'd3:    unit_char = 8'h65;
      3'd4:    unit_char = 8'h73;
      default: unit_char = 8'h00;
    endcase
  endfunction

endpackage

// ===== rtl/hbrp_parser.sv =====
// Byte parser: unit check, part tokenizer and part record register.
`include "assert_macros.svh"

module hbrp_parser
  import hbrp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_header_byte,
  input  logic       in_last_byte,
  input  logic       rec_ready,
  output logic       rec_valid,
  output rec_t       rec
);

  typedef enum logic [3:0] {
    PP_A_EMPTY = 4'd0,
    PP_A_SIGN  = 4'd1,
    PP_A_DIG   = 4'd2,
    PP_A_BLANK = 4'd3,
    PP_SKIP    = 4'd4,
    PP_B_EMPTY = 4'd5,
    PP_B_SIGN  = 4'd6,
    PP_B_DIG   = 4'd7,
    PP_B_BLANK = 4'd8
  } part_state_t;

  localparam logic [3:0] UNIT_NONE  = 4'd0;
  localparam logic [3:0] UNIT_DONE  = 4'd5;
  localparam logic [3:0] UNIT_TRAIL = 4'd6;
  localparam logic [3:0] UNIT_BAD   = 4'd15;

  logic             phase_r, phase_nxt, phase_b;
  logic [3:0]       up_r, up_nxt, up_b;
  part_state_t      pp_r, pp_nxt, pp_b, fin_pp;
  logic             neg_r, neg_nxt, neg_b, fin_neg;
  logic             suffix_r, suffix_nxt, suffix_b, fin_suffix;
  logic [ACC_W-1:0] acc_r, acc_nxt, acc_b, fin_acc;
  logic             ovf_r, ovf_nxt, ovf_b, fin_ovf;
  logic [OUT_W-1:0] pstart_r, pstart_nxt, pstart_b, fin_pstart;
  logic             rec_valid_r, rec_valid_nxt;
  rec_t             rec_r, rec_nxt;

  logic             in_fire, is_comma, emit, header_ok_b, fin_tok_ok;
  logic             digit, blank, dig_ovf, tok_ok, in_a, in_b;
  logic [3:0]       d;
  logic [7:0]       c_low;
  logic [ACC_W-1:0] acc_dig;
  logic [3:0]       pp_sub;
  logic [1:0]       rel, tok_res;
  logic             tok_bad, tok_add, tok_setneg;

  assign in_stall = rec_valid_r && !rec_ready;
  assign in_fire  = in_valid && !in_stall;
  assign is_comma = phase_r && (in_header_byte == CH_COMMA);
  assign emit     = in_fire && (is_comma || in_last_byte);

  assign digit   = (in_header_byte >= CH_ZERO) && (in_header_byte <= CH_NINE);
  assign d       = in_header_byte[3:0];
  assign blank   = is_blank(in_header_byte);
  assign dig_ovf = acc_r > ((d == 4'd9) ? DIGIT_LIMIT_NINE : DIGIT_LIMIT);
  assign acc_dig = (acc_r << 3) + (acc_r << 1) + {{(ACC_W-4){1'b0}}, d};
  assign tok_ok  = !ovf_r && (neg_r || !acc_r[ACC_W-1]);
  assign c_low   = ((in_header_byte >= CH_UP_A) && (in_header_byte <= CH_UP_Z)) ?
                   (in_header_byte + CASE_GAP) : in_header_byte;

  assign in_a   = pp_r < PP_SKIP;
  assign in_b   = (pp_r > PP_SKIP) && (pp_r <= PP_B_BLANK);
  assign pp_sub = pp_r - PP_B_EMPTY;
  assign rel    = in_b ? pp_sub[1:0] : pp_r[1:0];

  always_comb begin
    tok_bad    = 1'b0;
    tok_add    = 1'b0;
    tok_setneg = 1'b0;
    tok_res    = rel;
    if (digit && (rel != 2'd3)) begin
      tok_add = 1'b1;
      tok_res = 2'd2;
    end else if (rel == 2'd0) begin
      if (blank) begin
        tok_res = 2'd0;
      end else if (in_header_byte == CH_PLUS) begin
        tok_res = 2'd1;
      end else if ((in_header_byte == CH_MINUS) && in_b) begin
        tok_setneg = 1'b1;
        tok_res    = 2'd1;
      end else begin
        tok_bad = 1'b1;
      end
    end else if (((rel == 2'd2) || (rel == 2'd3)) && blank) begin
      tok_res = 2'd3;
    end else begin
      tok_bad = 1'b1;
    end
  end

  always_comb begin
    phase_b  = phase_r;
    up_b     = up_r;
    pp_b     = pp_r;
    neg_b    = neg_r;
    suffix_b = suffix_r;
    acc_b    = acc_r;
    ovf_b    = ovf_r;
    pstart_b = pstart_r;
    if (!phase_r) begin
      if (in_header_byte == CH_EQ) begin
        phase_b = 1'b1;
      end else if (blank) begin
        if (up_r == UNIT_DONE) begin
          up_b = UNIT_TRAIL;
        end else if ((up_r != UNIT_NONE) && (up_r != UNIT_TRAIL)) begin
          up_b = UNIT_BAD;
        end
      end else if ((up_r < UNIT_DONE) && (c_low == unit_char(up_r[2:0]))) begin
        up_b = up_r + 4'd1;
      end else begin
        up_b = UNIT_BAD;
      end
    end else if (!is_comma) begin
      if (in_a && (in_header_byte == CH_MINUS)) begin
        if (pp_r == PP_A_EMPTY) begin
          suffix_b = 1'b1;
          pp_b     = PP_B_EMPTY;
        end else if ((pp_r >= PP_A_DIG) && tok_ok) begin
          pstart_b = acc_r[OUT_W-1:0];
          pp_b     = PP_B_EMPTY;
        end else begin
          pp_b = PP_SKIP;
        end
        acc_b = '0;
        ovf_b = 1'b0;
        neg_b = 1'b0;
      end else if (in_a || in_b) begin
        if (tok_add && !ovf_r) begin
          if (dig_ovf) begin
            ovf_b = 1'b1;
          end else begin
            acc_b = acc_dig;
          end
        end
        if (tok_setneg) begin
          neg_b = 1'b1;
        end
        if (tok_bad) begin
          pp_b = PP_SKIP;
        end else if (in_b) begin
          pp_b = part_state_t'(4'({2'b00, tok_res} + PP_B_EMPTY));
        end else begin
          pp_b = part_state_t'({2'b00, tok_res});
        end
      end else begin
        pp_b = PP_SKIP;
      end
    end
  end

  assign header_ok_b = phase_b && ((up_b == UNIT_DONE) || (up_b == UNIT_TRAIL));

  assign fin_pp     = is_comma ? pp_r     : pp_b;
  assign fin_neg    = is_comma ? neg_r    : neg_b;
  assign fin_suffix = is_comma ? suffix_r : suffix_b;
  assign fin_acc    = is_comma ? acc_r    : acc_b;
  assign fin_ovf    = is_comma ? ovf_r    : ovf_b;
  assign fin_pstart = is_comma ? pstart_r : pstart_b;
  assign fin_tok_ok = !fin_ovf && (fin_neg || !fin_acc[ACC_W-1]);

  always_comb begin
    rec_nxt.last       = in_last_byte;
    rec_nxt.header_ok  = header_ok_b;
    rec_nxt.suffix     = fin_suffix;
    rec_nxt.neg        = fin_neg;
    rec_nxt.mag        = fin_acc;
    rec_nxt.part_start = fin_pstart;
    rec_nxt.kind       = REC_NONE;
    if (!in_last_byte || header_ok_b) begin
      if ((fin_pp == PP_B_EMPTY) && !fin_suffix) begin
        rec_nxt.kind = REC_OPEN;
      end else if (((fin_pp == PP_B_DIG) || (fin_pp == PP_B_BLANK)) && fin_tok_ok) begin
        rec_nxt.kind = REC_VALUE;
      end
    end
  end

  always_comb begin
    phase_nxt  = phase_r;
    up_nxt     = up_r;
    pp_nxt     = pp_r;
    neg_nxt    = neg_r;
    suffix_nxt = suffix_r;
    acc_nxt    = acc_r;
    ovf_nxt    = ovf_r;
    pstart_nxt = pstart_r;
    if (in_fire) begin
      phase_nxt  = phase_b;
      up_nxt     = up_b;
      pp_nxt     = pp_b;
      neg_nxt    = neg_b;
      suffix_nxt = suffix_b;
      acc_nxt    = acc_b;
      ovf_nxt    = ovf_b;
      pstart_nxt = pstart_b;
      if (in_last_byte || is_comma) begin
        pp_nxt     = PP_A_EMPTY;
        neg_nxt    = 1'b0;
        suffix_nxt = 1'b0;
        acc_nxt    = '0;
        ovf_nxt    = 1'b0;
        pstart_nxt = '0;
      end
      if (in_last_byte) begin
        phase_nxt = 1'b0;
        up_nxt    = UNIT_NONE;
      end
    end
  end

  assign rec_valid_nxt = emit ? 1'b1 : (rec_ready ? 1'b0 : rec_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= 1'b0;
      up_r        <= UNIT_NONE;
      pp_r        <= PP_A_EMPTY;
      neg_r       <= 1'b0;
      suffix_r    <= 1'b0;
      acc_r       <= '0;
      ovf_r       <= 1'b0;
      pstart_r    <= '0;
      rec_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      up_r        <= up_nxt;
      pp_r        <= pp_nxt;
      neg_r       <= neg_nxt;
      suffix_r    <= suffix_nxt;
      acc_r       <= acc_nxt;
      ovf_r       <= ovf_nxt;
      pstart_r    <= pstart_nxt;
      rec_valid_r <= rec_valid_nxt;
      if (emit) begin
        rec_r <= rec_nxt;
      end
    end
  end

  assign rec_valid = rec_valid_r;
  assign rec       = rec_r;

  `HBRP_ASSERT_NEXT(a_clear_after_last, in_fire && in_last_byte,
    !phase_r && (up_r == UNIT_NONE) && (pp_r == PP_A_EMPTY) && (acc_r == '0),
    "parse state not cleared after last byte")
  `HBRP_ASSERT_IMP(a_ovf_in_number, ovf_r,
    (pp_r == PP_A_DIG) || (pp_r == PP_A_BLANK) || (pp_r == PP_B_DIG) ||
    (pp_r == PP_B_BLANK) || (pp_r == PP_SKIP),
    "overflow flag set outside a number")
  `HBRP_ASSERT_IMP(a_acc_bound, phase_r, acc_r <= TWO63,
    "digit accumulator above 2^63")

endmodule

// ===== rtl/hbrp_span.sv =====
// Span unit: range arithmetic, range tally and verdict result register.
`include "assert_macros.svh"

module hbrp_span
  import hbrp_pkg::*;
#(
  parameter int unsigned OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [OFFSET_BITS-1:0] obj_size,
  input  logic                   rec_valid,
  output logic                   rec_ready,
  input  rec_t                   rec,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [1:0]             out_verdict,
  output logic [OUT_W-1:0]       out_range_first,
  output logic [OUT_W-1:0]       out_range_last
);

  logic [ACC_W-1:0] fs64, fs_m1, v, sfx_sum, sfx_diff;
  logic             v_lt, sfx_lt, fs_pos;

  logic             b_valid_r, b_valid_nxt;
  logic             b_last_r, b_last_nxt;
  logic             b_hdr_ok_r, b_hdr_ok_nxt;
  logic             b_push_r, b_push_nxt;
  logic             b_end_pos_r, b_end_pos_nxt;
  logic [ACC_W-1:0] b_start_r, b_start_nxt;
  logic [ACC_W-1:0] b_end_m1_r, b_end_m1_nxt;

  logic [1:0]       tally_r, tally_nxt;
  logic             outside_r, outside_nxt;
  logic             empty_r, empty_nxt;
  logic [OUT_W-1:0] kept_first_r, kept_first_nxt;
  logic [OUT_W-1:0] kept_last_r, kept_last_nxt;

  logic             out_valid_r, out_valid_nxt;
  verdict_t         verdict_r, verdict_nxt;
  logic [OUT_W-1:0] first_r, first_nxt;
  logic [OUT_W-1:0] last_r, last_nxt;

  logic             out_free, b_load, c_fire;

  assign fs64     = {{(ACC_W-OFFSET_BITS){1'b0}}, obj_size};
  assign fs_m1    = fs64 - 64'd1;
  assign fs_pos   = fs64 != '0;
  assign v        = rec.neg ? (~rec.mag + 64'd1) : rec.mag;
  assign v_lt     = $signed(v) < $signed(fs64);
  assign sfx_sum  = fs64 + rec.mag;
  assign sfx_diff = fs64 - rec.mag;
  assign sfx_lt   = rec.mag < fs64;

  assign out_free  = !out_valid_r || !out_stall;
  assign c_fire    = b_valid_r && (!b_last_r || out_free);
  assign rec_ready = !b_valid_r || c_fire;
  assign b_load    = rec_valid && rec_ready;

  always_comb begin
    b_push_nxt    = 1'b0;
    b_start_nxt   = '0;
    b_end_m1_nxt  = '0;
    b_end_pos_nxt = 1'b0;
    unique case (rec.kind)
      REC_OPEN: begin
        b_push_nxt    = 1'b1;
        b_start_nxt   = {1'b0, rec.part_start};
        b_end_m1_nxt  = fs_m1;
        b_end_pos_nxt = fs_pos;
      end
      REC_VALUE: begin
        b_push_nxt = 1'b1;
        if (rec.suffix) begin
          if (rec.neg) begin
            b_start_nxt = sfx_sum;
          end else begin
            b_start_nxt = sfx_lt ? sfx_diff : '0;
          end
          b_end_m1_nxt  = fs_m1;
          b_end_pos_nxt = fs_pos;
        end else begin
          b_start_nxt   = {1'b0, rec.part_start};
          b_end_m1_nxt  = v_lt ? v : fs_m1;
          b_end_pos_nxt = v_lt ? (!rec.neg || (rec.mag == '0)) : fs_pos;
        end
      end
      default: begin
        b_push_nxt = 1'b0;
      end
    endcase
  end

  assign b_last_nxt   = rec.last;
  assign b_hdr_ok_nxt = rec.header_ok;
  assign b_valid_nxt  = b_load ? 1'b1 : (c_fire ? 1'b0 : b_valid_r);

  always_comb begin
    tally_nxt      = tally_r;
    outside_nxt    = outside_r;
    empty_nxt      = empty_r;
    kept_first_nxt = kept_first_r;
    kept_last_nxt  = kept_last_r;
    if (b_push_r) begin
      if (tally_r == 2'd0) begin
        kept_first_nxt = b_start_r[OUT_W-1:0];
        kept_last_nxt  = b_end_pos_r ? b_end_m1_r[OUT_W-1:0] : '0;
      end
      if (tally_r != 2'd2) begin
        tally_nxt = tally_r + 2'd1;
      end
      if (b_start_r >= fs64) begin
        outside_nxt = 1'b1;
      end
      if (!b_end_pos_r || (b_start_r > b_end_m1_r)) begin
        empty_nxt = 1'b1;
      end
    end
  end

  always_comb begin
    first_nxt = '0;
    last_nxt  = '0;
    priority if (!b_hdr_ok_r) begin
      verdict_nxt = VERDICT_MALFORMED;
    end else if (tally_nxt == 2'd0) begin
      verdict_nxt = VERDICT_MALFORMED;
    end else if (outside_nxt) begin
      verdict_nxt = VERDICT_UNSAT;
    end else if (empty_nxt) begin
      verdict_nxt = VERDICT_MALFORMED;
    end else if (tally_nxt == 2'd2) begin
      verdict_nxt = VERDICT_MULTI;
    end else begin
      verdict_nxt = VERDICT_OK;
      first_nxt   = kept_first_nxt;
      last_nxt    = kept_last_nxt;
    end
  end

  assign out_valid_nxt = (c_fire && b_last_r) ? 1'b1 : (out_free ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r    <= 1'b0;
      tally_r      <= 2'd0;
      outside_r    <= 1'b0;
      empty_r      <= 1'b0;
      kept_first_r <= '0;
      kept_last_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      b_valid_r   <= b_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (b_load) begin
        b_last_r    <= b_last_nxt;
        b_hdr_ok_r  <= b_hdr_ok_nxt;
        b_push_r    <= b_push_nxt;
        b_start_r   <= b_start_nxt;
        b_end_m1_r  <= b_end_m1_nxt;
        b_end_pos_r <= b_end_pos_nxt;
      end
      if (c_fire) begin
        if (b_last_r) begin
          tally_r      <= 2'd0;
          outside_r    <= 1'b0;
          empty_r      <= 1'b0;
          kept_first_r <= '0;
          kept_last_r  <= '0;
          verdict_r    <= verdict_nxt;
          first_r      <= first_nxt;
          last_r       <= last_nxt;
        end else begin
          tally_r      <= tally_nxt;
          outside_r    <= outside_nxt;
          empty_r      <= empty_nxt;
          kept_first_r <= kept_first_nxt;
          kept_last_r  <= kept_last_nxt;
        end
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_verdict     = verdict_r;
  assign out_range_first = first_r;
  assign out_range_last  = last_r;

  `HBRP_ASSERT_IMP(a_ok_ordered, out_valid_r && (verdict_r == VERDICT_OK),
    first_r <= last_r, "single range with first above last")
  `HBRP_ASSERT_IMP(a_fail_zero, out_valid_r && (verdict_r != VERDICT_OK),
    (first_r == '0) && (last_r == '0), "range fields nonzero on a failed verdict")
  `HBRP_ASSERT_IMP(a_result_from_last, $rose(out_valid_r),
    $past(b_valid_r && b_last_r), "result without a last-byte record")

endmodule

// ===== rtl/http_byte_range_parser.sv =====
// Top level of the HTTP byte range header parser.
//
// Channel  Dir  Handshake              Carries
// in       in   in_valid / in_stall    in_header_byte, in_last_byte
// out      out  out_valid / out_stall  out_verdict, out_range_first, out_range_last
// cfg      in   APB cfg_psel/penable   obj_size, 63 bits on a 64-bit bus, byte address 0
//
// One header byte is taken every cycle while in_stall is low; parse state updates
// in the cycle it arrives. The edge that takes the last byte loads the part record;
// then the span registers load from it, and the verdict registers from them.
// in_stall rises only while a part record waits behind a held result.
// Synchronous active-low reset clears parse state, obj_size and every valid flag.

module http_byte_range_parser
  import hbrp_pkg::*;
#(
  parameter int unsigned OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_header_byte,
  input  logic              in_last_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_verdict,
  output logic [OUT_W-1:0]  out_range_first,
  output logic [OUT_W-1:0]  out_range_last,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  logic [OFFSET_BITS-1:0] obj_size_r, obj_size_nxt;
  logic                   cfg_wr, cfg_hit;
  logic                   rec_valid, rec_ready;
  rec_t                   rec;

  assign cfg_pready = 1'b1;
  assign cfg_hit    = cfg_paddr[CFG_AW-1] == CFG_IDX_FILE_SIZE;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_hit;
  assign cfg_prdata = cfg_hit ? {{(CFG_DW-OFFSET_BITS){1'b0}}, obj_size_r} : '0;

  assign obj_size_nxt = cfg_wr ? cfg_pwdata[OFFSET_BITS-1:0] : obj_size_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      obj_size_r <= '0;
    end else begin
      obj_size_r <= obj_size_nxt;
    end
  end

  hbrp_parser u_parser (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_header_byte (in_header_byte),
    .in_last_byte   (in_last_byte),
    .rec_ready      (rec_ready),
    .rec_valid      (rec_valid),
    .rec            (rec)
  );

  hbrp_span #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_span (
    .clk             (clk),
    .rst_n           (rst_n),
    .obj_size        (obj_size_r),
    .rec_valid       (rec_valid),
    .rec_ready       (rec_ready),
    .rec             (rec),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_verdict     (out_verdict),
    .out_range_first (out_range_first),
    .out_range_last  (out_range_last)
  );

endmodule

// ===== tb/sv/hbrp_checker.sv =====
// Checker for the byte range parser: predicts each verdict and compares it with the result channel.
module hbrp_checker
  import hbrp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [7:0]        in_header_byte,
  input  logic              in_last_byte,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [1:0]        out_verdict,
  input  logic [OUT_W-1:0]  out_range_first,
  input  logic [OUT_W-1:0]  out_range_last,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic              cfg_pready,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output int                fail_count,
  output int                outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_AW-1:0] FILE_SIZE_ADDR = CFG_AW'(8 * int'(CFG_IDX_FILE_SIZE));
  localparam logic [39:0] UNIT_TEXT = "bytes";

  localparam logic [3:0] UNIT_EMPTY = 4'd0;
  localparam logic [3:0] UNIT_DONE  = 4'd5;
  localparam logic [3:0] UNIT_TRAIL = 4'd6;
  localparam logic [3:0] UNIT_BAD   = 4'd15;

  localparam logic [3:0] TOK_EMPTY  = 4'd0;
  localparam logic [3:0] TOK_SIGN   = 4'd1;
  localparam logic [3:0] TOK_DIGITS = 4'd2;
  localparam logic [3:0] TOK_BLANK  = 4'd3;
  localparam logic [3:0] PART_SKIP  = 4'd4;
  localparam logic [3:0] PART_B     = 4'd5;
  localparam logic [3:0] TOK_BAD    = 4'd15;

  typedef struct packed {
    verdict_t         verdict;
    logic [OUT_W-1:0] first_off;
    logic [OUT_W-1:0] last_off;
  } span_result_t;

  logic [OUT_W-1:0] size_q;
  logic             after_eq;
  logic [3:0]       unit_pos;
  logic [3:0]       part_pos;
  logic             neg_sign;
  logic             suffix_form;
  logic [63:0]      mag;
  logic             mag_over;
  logic [63:0]      start_val;
  logic [1:0]       span_count;
  logic             outside_seen;
  logic             empty_seen;
  logic [OUT_W-1:0] keep_first;
  logic [OUT_W-1:0] keep_last;
  span_result_t     verdict_q[$];
  int               errors = 0;

  function automatic logic blank_char(logic [7:0] c);
    return (c == CH_SPACE) || (c inside {[8'h09:8'h0d]});
  endfunction

  function automatic void clear_number();
    mag = '0;
    mag_over = 1'b0;
    neg_sign = 1'b0;
  endfunction

  function automatic void clear_header();
    after_eq = 1'b0;
    unit_pos = UNIT_EMPTY;
    part_pos = TOK_EMPTY;
    suffix_form = 1'b0;
    start_val = '0;
    span_count = '0;
    outside_seen = 1'b0;
    empty_seen = 1'b0;
    keep_first = '0;
    keep_last = '0;
    clear_number();
  endfunction

  function automatic logic number_fits();
    if (mag_over) return 1'b0;
    if (neg_sign) return mag <= TWO63;
    return mag < TWO63;
  endfunction

  function automatic void add_digit(logic [63:0] d);
    if (!mag_over) begin
      if (mag > (TWO63 - d) / 64'd10) mag_over = 1'b1;
      else mag = mag * 64'd10 + d;
    end
  endfunction

  function automatic logic [3:0] token_step(logic [3:0] rel, logic [7:0] c, logic minus_ok);
    if (c >= CH_ZERO && c <= CH_NINE && rel <= TOK_DIGITS) begin
      add_digit(64'(c - CH_ZERO));
      return TOK_DIGITS;
    end
    if (rel == TOK_EMPTY) begin
      if (blank_char(c)) return TOK_EMPTY;
      if (c == CH_PLUS) return TOK_SIGN;
      if (c == CH_MINUS && minus_ok) begin
        neg_sign = 1'b1;
        return TOK_SIGN;
      end
      return TOK_BAD;
    end
    if ((rel == TOK_DIGITS || rel == TOK_BLANK) && blank_char(c)) return TOK_BLANK;
    return TOK_BAD;
  endfunction

  function automatic void record_span(logic [63:0] s, logic signed [63:0] e);
    if (span_count == 2'd0) begin
      keep_first = s[OUT_W-1:0];
      keep_last = (e > 0) ? OUT_W'(e - 64'sd1) : '0;
    end
    if (span_count < 2'd2) span_count++;
    if (s >= {1'b0, size_q}) outside_seen = 1'b1;
    if (e <= 0 || s >= $unsigned(e)) empty_seen = 1'b1;
  endfunction

  function automatic void close_part();
    logic signed [63:0] size_s;
    logic signed [63:0] v;
    logic signed [63:0] e;
    logic [63:0]        s;
    size_s = $signed({1'b0, size_q});
    if (part_pos == PART_B) begin
      if (!suffix_form) record_span(start_val, size_s);
    end else if (part_pos == PART_B + TOK_DIGITS || part_pos == PART_B + TOK_BLANK) begin
      if (number_fits()) begin
        if (suffix_form) begin
          if (neg_sign) s = {1'b0, size_q} + mag;
          else s = (mag < {1'b0, size_q}) ? {1'b0, size_q} - mag : 64'd0;
          record_span(s, size_s);
        end else begin
          v = neg_sign ? -$signed(mag) : $signed(mag);
          e = (v < size_s) ? v + 64'sd1 : size_s;
          record_span(start_val, e);
        end
      end
    end
    part_pos = TOK_EMPTY;
    suffix_form = 1'b0;
    start_val = '0;
    clear_number();
  endfunction

  function automatic void part_step(logic [7:0] c);
    logic [3:0] r;
    if (part_pos < PART_SKIP) begin
      if (c == CH_MINUS) begin
        if (part_pos == TOK_EMPTY) begin
          suffix_form = 1'b1;
          part_pos = PART_B;
        end else if (part_pos >= TOK_DIGITS && number_fits()) begin
          start_val = mag;
          part_pos = PART_B;
        end else begin
          part_pos = PART_SKIP;
        end
        clear_number();
      end else begin
        r = token_step(part_pos, c, 1'b0);
        part_pos = (r == TOK_BAD) ? PART_SKIP : r;
      end
    end else if (part_pos > PART_SKIP && part_pos <= PART_B + TOK_BLANK) begin
      r = token_step(part_pos - PART_B, c, 1'b1);
      part_pos = (r == TOK_BAD) ? PART_SKIP : r + PART_B;
    end else begin
      part_pos = PART_SKIP;
    end
  endfunction

  function automatic void unit_step(logic [7:0] c);
    logic [7:0] lc;
    if (blank_char(c)) begin
      if (unit_pos == UNIT_DONE) unit_pos = UNIT_TRAIL;
      else if (unit_pos != UNIT_EMPTY && unit_pos != UNIT_TRAIL) unit_pos = UNIT_BAD;
    end else begin
      lc = (c >= CH_UP_A && c <= CH_UP_Z) ? c + CASE_GAP : c;
      if (unit_pos < UNIT_DONE && lc == UNIT_TEXT[8 * (4 - int'(unit_pos)) +: 8])
        unit_pos++;
      else
        unit_pos = UNIT_BAD;
    end
  endfunction

  function automatic void header_step(logic [7:0] c, logic fin);
    span_result_t r;
    if (!after_eq) begin
      if (c == CH_EQ) after_eq = 1'b1;
      else unit_step(c);
    end else if (c == CH_COMMA) begin
      close_part();
    end else begin
      part_step(c);
    end
    if (fin) begin
      r.verdict = VERDICT_MALFORMED;
      r.first_off = '0;
      r.last_off = '0;
      if (after_eq && (unit_pos == UNIT_DONE || unit_pos == UNIT_TRAIL)) begin
        close_part();
        if (span_count == 2'd0) r.verdict = VERDICT_MALFORMED;
        else if (outside_seen) r.verdict = VERDICT_UNSAT;
        else if (empty_seen) r.verdict = VERDICT_MALFORMED;
        else if (span_count > 2'd1) r.verdict = VERDICT_MULTI;
        else begin
          r.verdict = VERDICT_OK;
          r.first_off = keep_first;
          r.last_off = keep_last;
        end
      end
      verdict_q.push_back(r);
      clear_header();
    end
  endfunction

  always @(posedge clk) begin : monitor
    span_result_t want;
    if (!rst_n) begin
      size_q = '0;
      clear_header();
      verdict_q.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_paddr == FILE_SIZE_ADDR)
        size_q = cfg_pwdata[OUT_W-1:0];
      if (in_valid && !in_stall) header_step(in_header_byte, in_last_byte);
      if (out_valid && !out_stall) begin
        if (verdict_q.size() == 0) begin
          errors++;
          $error("unexpected transaction: verdict %0d first %0d last %0d",
                 out_verdict, out_range_first, out_range_last);
        end else begin
          want = verdict_q.pop_front();
          if (out_verdict !== want.verdict) begin
            errors++;
            $error("verdict: expected %0d, actual %0d", want.verdict, out_verdict);
          end
          if (out_range_first !== want.first_off) begin
            errors++;
            $error("range_first: expected %0d, actual %0d", want.first_off, out_range_first);
          end
          if (out_range_last !== want.last_off) begin
            errors++;
            $error("range_last: expected %0d, actual %0d", want.last_off, out_range_last);
          end
        end
      end
    end
    outstanding <= verdict_q.size();
    fail_count <= errors;
  end

endmodule

// ===== tb/sv/testbench.sv =====
// Top of the byte range parser testbench: clock, reset, stimulus and final verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import hbrp_pkg::*;

  localparam logic [CFG_AW-1:0] FILE_SIZE_ADDR = CFG_AW'(8 * int'(CFG_IDX_FILE_SIZE));
  localparam logic [39:0] UNIT_TEXT = "bytes";
  localparam logic [47:0] BLANK_SET = {CH_SPACE, CH_TAB, 8'h0a, 8'h0b, 8'h0c, CH_CR};
  localparam int DRAIN = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_BYTES = 120;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [7:0]        in_header_byte;
  logic              in_last_byte;
  logic              out_valid;
  logic              out_stall;
  logic [1:0]        out_verdict;
  logic [OUT_W-1:0]  out_range_first;
  logic [OUT_W-1:0]  out_range_last;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;
  int                fail_count;
  int                pending;

  logic              calm = 1'b0;
  logic [OUT_W-1:0]  size_now = '0;
  logic [7:0]        hdr[$];
  int                sent_bytes = 0;

  http_byte_range_parser uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_header_byte  (in_header_byte),
    .in_last_byte    (in_last_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_verdict     (out_verdict),
    .out_range_first (out_range_first),
    .out_range_last  (out_range_last),
    .cfg_psel        (cfg_psel),
    .cfg_penable     (cfg_penable),
    .cfg_pwrite      (cfg_pwrite),
    .cfg_paddr       (cfg_paddr),
    .cfg_pwdata      (cfg_pwdata),
    .cfg_prdata      (cfg_prdata),
    .cfg_pready      (cfg_pready)
  );

  hbrp_checker range_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_header_byte  (in_header_byte),
    .in_last_byte    (in_last_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_verdict     (out_verdict),
    .out_range_first (out_range_first),
    .out_range_last  (out_range_last),
    .cfg_psel        (cfg_psel),
    .cfg_penable     (cfg_penable),
    .cfg_pwrite      (cfg_pwrite),
    .cfg_pready      (cfg_pready),
    .cfg_paddr       (cfg_paddr),
    .cfg_pwdata      (cfg_pwdata),
    .fail_count      (fail_count),
    .outstanding     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      out_stall <= !calm && ($urandom_range(0, 99) < 25);
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_psel || !rst_n)
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("testbench: done, errors");
    $finish;
  end

  task automatic push_byte(logic [7:0] b, logic fin);
    in_valid <= 1'b1;
    in_header_byte <= b;
    in_last_byte <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_bytes++;
    if (!calm) begin
      while ($urandom_range(0, 99) < 25) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
  endtask

  task automatic send_header();
    for (int i = 0; i < hdr.size(); i++) push_byte(hdr[i], i == hdr.size() - 1);
    hdr.delete();
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_size(logic [63:0] v);
    settle();
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= FILE_SIZE_ADDR;
    cfg_pwdata <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    size_now = v[OUT_W-1:0];
  endtask

  function automatic void put_str(string s);
    for (int i = 0; i < s.len(); i++) hdr.push_back(s[i]);
  endfunction

  task automatic header(string s);
    put_str(s);
    send_header();
  endtask

  function automatic void put_pad();
    int k;
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 2)) begin
        k = $urandom_range(0, 5);
        hdr.push_back(BLANK_SET[8 * k +: 8]);
      end
    end
  endfunction

  function automatic void put_number(logic minus_ok);
    logic [63:0] v;
    logic [63:0] sz;
    sz = {1'b0, size_now};
    if ($urandom_range(0, 99) < 20) hdr.push_back(CH_PLUS);
    else if (minus_ok && $urandom_range(0, 99) < 15) hdr.push_back(CH_MINUS);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom_range(0, 300);
      4: v = sz - 64'd1;
      5: v = sz;
      6: v = sz + 64'd1;
      7: v = {$urandom, $urandom};
      8: v = TWO63 - 64'd1 + 64'($urandom_range(0, 2));
      default: v = (sz == 0) ? 64'd0 : {$urandom, $urandom} % sz;
    endcase
    if ($urandom_range(0, 19) == 0) hdr.push_back(CH_ZERO);
    put_str($sformatf("%0d", v));
    if ($urandom_range(0, 39) == 0) hdr.push_back(CH_NINE);
  endfunction

  function automatic void put_part();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: begin
        put_pad();
        put_number(1'b0);
        put_pad();
        hdr.push_back(CH_MINUS);
        put_pad();
        put_number(1'b1);
        put_pad();
      end
      5, 6: begin
        put_pad();
        put_number(1'b0);
        put_pad();
        hdr.push_back(CH_MINUS);
        put_pad();
      end
      7, 8: begin
        put_pad();
        hdr.push_back(CH_MINUS);
        put_pad();
        put_number(1'b1);
        put_pad();
      end
      default: begin
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(0, 1) == 0) hdr.push_back(8'($urandom_range(0, 255)));
          else hdr.push_back(CH_MINUS);
        end
      end
    endcase
  endfunction

  function automatic void put_header();
    int sel;
    int bad_pos;
    int parts;
    logic [7:0] c;
    sel = $urandom_range(0, 99);
    if (sel < 4) begin
      repeat ($urandom_range(1, 8)) hdr.push_back(8'($urandom_range(0, 255)));
    end else begin
      bad_pos = (sel < 10) ? $urandom_range(0, 4) : -1;
      put_pad();
      for (int i = 0; i < 5; i++) begin
        c = UNIT_TEXT[8 * (4 - i) +: 8];
        if (i == bad_pos) c = 8'($urandom_range(0, 255));
        else if ($urandom_range(0, 2) == 0) c = c - CASE_GAP;
        hdr.push_back(c);
      end
      put_pad();
      if ($urandom_range(0, 29) != 0) hdr.push_back(CH_EQ);
      sel = $urandom_range(0, 9);
      parts = (sel < 6) ? 1 : (sel < 9) ? 2 : 3;
      for (int i = 0; i < parts; i++) begin
        if (i > 0) hdr.push_back(CH_COMMA);
        if ($urandom_range(0, 9) != 0) put_part();
      end
      if ($urandom_range(0, 19) == 0) hdr.push_back(CH_COMMA);
    end
  endfunction

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_header_byte = '0;
    in_last_byte = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_size(64'd1000);
    header("bytes=0-499");
    header(" BYTES =  -200 ");
    header("bytes=500-");
    header("bytes=0-0,5-9");
    header("bytes=1000-");
    header("bytes=-0");
    header("bytes=--5");
    header("bytes=5-3");
    header("bytes=0--1");
    header("bytes=+5-+9");
    header("bytes=9223372036854775807-");
    header("bytes=9223372036854775808-");
    header("bytes=0-99999999999999999999");
    header("bytes=0--9223372036854775808");
    header("bytes=,,0-1,");
    header("bytes=-");
    header("items=0-1");
    header("bytes");
    header("=");
    header("bytes=0-1=2");
    header("bytes=a-1,2-3");
    header("bytes = 1 - 2");
    put_str("bytes=0-");
    hdr.push_back(8'hff);
    send_header();
    put_str("bytes=");
    hdr.push_back(8'h0b);
    put_str("7");
    hdr.push_back(8'h0c);
    put_str("-\t8\r\n");
    send_header();
    hdr.push_back(8'h00);
    send_header();

    write_size(64'd0);
    header("bytes=0-");
    header("bytes=-5");

    write_size(64'hffff_ffff_ffff_ffff);
    header("bytes=0-");
    header("bytes=9223372036854775806-9223372036854775807");
    header("bytes=--9223372036854775808");
    header("bytes=-9223372036854775808");
    header("bytes=-1");

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: write_size(64'($urandom_range(1, 4000)));
        1: write_size(64'd0);
        2: write_size(64'hffff_ffff_ffff_ffff);
        3: write_size(64'($urandom_range(1, 4000)));
        4: write_size({$urandom, $urandom});
        default: write_size(64'd1);
      endcase
      calm = (phase == 3);
      sent_bytes = 0;
      while (sent_bytes < PHASE_BYTES) begin
        put_header();
        send_header();
      end
    end
    calm = 1'b0;

    settle();
    if (fail_count == 0 && pending == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

endmodule
